@@ hw/rtl/mcbs_pkg.sv @@
package mcbs_pkg;

  localparam int unsigned FitW   = 32;
  localparam int unsigned RatioW = 17;
  localparam int unsigned RmseW  = 32;
  localparam int unsigned ScoreW = 17;
  localparam int unsigned IdW    = 16;
  localparam int unsigned GatesW = 3;
  localparam int unsigned DataW  = 32;
  localparam int unsigned AddrW  = 4;

  localparam logic [1:0] REG_FIT_LIMIT   = 2'd0;
  localparam logic [1:0] REG_RATIO_FLOOR = 2'd1;
  localparam logic [1:0] REG_RMSE_CEIL   = 2'd2;

  localparam logic [FitW-1:0] FIT_LIMIT_RST = 32'h0001_0000;

  typedef struct packed {
    logic [FitW-1:0]   fit_limit;
    logic [RatioW-1:0] ratio_floor;
    logic [RmseW-1:0]  rmse_ceil;
  } cfg_t;

  typedef struct packed {
    logic              success;
    logic              converged;
    logic [FitW-1:0]   fitness;
    logic [RatioW-1:0] ratio;
    logic [RmseW-1:0]  rmse;
    logic [ScoreW-1:0] score;
    logic [IdW-1:0]    cand_id;
    logic              last;
  } cand_t;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic              converged;
    logic [FitW-1:0]   fitness;
    logic [RatioW-1:0] ratio;
    logic [RmseW-1:0]  rmse;
    logic [ScoreW-1:0] score;
  } slot_t;

  typedef struct packed {
    logic              best_ok;
    logic [IdW-1:0]    best_id;
    logic [GatesW-1:0] best_gates;
    logic [FitW-1:0]   best_fitness;
    logic [RatioW-1:0] best_ratio;
    logic [RmseW-1:0]  best_rmse;
    logic [ScoreW-1:0] best_score;
  } result_t;

  function automatic logic [GatesW-1:0] gates_of(cfg_t cfg, logic conv,
                                                 logic [FitW-1:0] fit,
                                                 logic [RatioW-1:0] ratio,
                                                 logic [RmseW-1:0] rmse);
    logic g_fit;
    logic g_ratio;
    logic g_rmse;
    g_fit   = (fit <= cfg.fit_limit);
    g_ratio = (cfg.ratio_floor == '0) || (ratio >= cfg.ratio_floor);
    g_rmse  = (cfg.rmse_ceil == '0) || (rmse <= cfg.rmse_ceil);
    return GatesW'(conv) + GatesW'(g_fit) + GatesW'(g_ratio) + GatesW'(g_rmse);
  endfunction

endpackage

@@ hw/rtl/mcbs_in_if.sv @@
interface mcbs_in_if;
  logic        valid;
  logic        ready;
  logic        success;
  logic        converged;
  logic [31:0] fitness;
  logic [16:0] ratio;
  logic [31:0] rmse;
  logic [16:0] score;
  logic [15:0] cand_id;
  logic        last;

  modport source (
    output valid, success, converged, fitness, ratio, rmse,
           score, cand_id, last,
    input  ready
  );
  modport sink (
    input  valid, success, converged, fitness, ratio, rmse,
           score, cand_id, last,
    output ready
  );
endinterface

@@ hw/rtl/mcbs_out_if.sv @@
interface mcbs_out_if;
  logic        valid;
  logic        ready;
  logic        best_ok;
  logic [15:0] best_id;
  logic [2:0]  best_gates;
  logic [31:0] best_fitness;
  logic [16:0] best_ratio;
  logic [31:0] best_rmse;
  logic [16:0] best_score;

  modport source (
    output valid, best_ok, best_id, best_gates, best_fitness, best_ratio,
           best_rmse, best_score,
    input  ready
  );
  modport sink (
    input  valid, best_ok, best_id, best_gates, best_fitness, best_ratio,
           best_rmse, best_score,
    output ready
  );
endinterface

@@ hw/rtl/mcbs_cfg.sv @@
module mcbs_cfg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [mcbs_pkg::AddrW-1:0] paddr,
  input  logic [mcbs_pkg::DataW-1:0] pwdata,
  output logic [mcbs_pkg::DataW-1:0] prdata,
  output logic                  pready,
  output mcbs_pkg::cfg_t        cfg
);
  import mcbs_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [1:0] idx;
  logic       wr_en;

  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_FIT_LIMIT:   cfg_nxt.fit_limit   = pwdata[FitW-1:0];
        REG_RATIO_FLOOR: cfg_nxt.ratio_floor = pwdata[RatioW-1:0];
        REG_RMSE_CEIL:   cfg_nxt.rmse_ceil   = pwdata[RmseW-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FIT_LIMIT:   prdata = DataW'(cfg_r.fit_limit);
      REG_RATIO_FLOOR: prdata = DataW'(cfg_r.ratio_floor);
      REG_RMSE_CEIL:   prdata = DataW'(cfg_r.rmse_ceil);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fit_limit   <= FIT_LIMIT_RST;
      cfg_r.ratio_floor <= '0;
      cfg_r.rmse_ceil   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ hw/rtl/match_candidate_best_selector.sv @@
// match candidate best selector
// in_ch carries one scored match candidate per request (valid/ready); the
// block keeps the best successful and the best failed candidate of the
// current batch. a request with last set closes the batch: one result is
// sent on out_ch, the best successful candidate or else the best failed
// one, and both stores are emptied. other requests give no result.
// a candidate is registered at the input and ranked against its store
// from that register; on a last request the result is registered in
// out_r, which drives out_ch, when the request leaves the input register.
// throughput: one request per cycle, set by the single compare stage
// between the input register and the two-entry store, while no last
// request waits on a stalled out_ch.
// the apb port (psel/penable/pwrite/paddr/pwdata/prdata/pready) holds
// the fitness limit at 0x0, the ratio floor at 0x4 and the rmse ceiling
// at 0x8; pready is always high. write registers only while idle.
// reset (rst_n low, synchronous) empties the stores and the pipeline and
// loads the register defaults. when out_ch is stalled, non-last requests
// keep flowing; a last request waits in the input register until the
// pending result is taken.
module match_candidate_best_selector (
  input  logic                       clk,
  input  logic                       rst_n,
  mcbs_in_if.sink                    in_ch,
  mcbs_out_if.source                 out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mcbs_pkg::AddrW-1:0] paddr,
  input  logic [mcbs_pkg::DataW-1:0] pwdata,
  output logic [mcbs_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import mcbs_pkg::*;

  cfg_t        cfg;
  cand_t       s1_r;
  logic        s1_valid_r;
  slot_t       slot_r [2];
  logic [1:0]  slot_valid_r;
  logic [1:0]  slot_valid_nxt;
  result_t     out_r;
  logic        out_valid_r;

  cand_t       in_cand;
  slot_t       new_slot;
  slot_t       cur;
  slot_t       chosen;
  logic        s;
  logic        c;
  logic        adv;
  logic        in_acc;
  logic        beats;
  logic        take;
  logic [GatesW-1:0] gn;
  logic [GatesW-1:0] go;
  logic [1:0]  upd_valid;
  result_t     res;

  mcbs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_cand.success   = in_ch.success;
  assign in_cand.converged = in_ch.converged;
  assign in_cand.fitness   = in_ch.fitness;
  assign in_cand.ratio     = in_ch.ratio;
  assign in_cand.rmse      = in_ch.rmse;
  assign in_cand.score     = in_ch.score;
  assign in_cand.cand_id   = in_ch.cand_id;
  assign in_cand.last      = in_ch.last;

  assign adv         = s1_valid_r && (!s1_r.last || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // rank the registered candidate against its store
  always_comb begin
    s                  = s1_r.success;
    new_slot.id        = s1_r.cand_id;
    new_slot.converged = s1_r.converged;
    new_slot.fitness   = s1_r.fitness;
    new_slot.ratio     = s1_r.ratio;
    new_slot.rmse      = s1_r.rmse;
    new_slot.score     = s1_r.score;
    cur = slot_r[s];
    gn  = gates_of(cfg, new_slot.converged, new_slot.fitness, new_slot.ratio,
                   new_slot.rmse);
    go  = gates_of(cfg, cur.converged, cur.fitness, cur.ratio, cur.rmse);
    if (gn != go) begin
      beats = gn > go;
    end else if (new_slot.ratio != cur.ratio) begin
      beats = new_slot.ratio > cur.ratio;
    end else if (new_slot.rmse != cur.rmse) begin
      beats = new_slot.rmse < cur.rmse;
    end else if (new_slot.fitness != cur.fitness) begin
      beats = new_slot.fitness < cur.fitness;
    end else begin
      beats = new_slot.score < cur.score;
    end
    take = !slot_valid_r[s] || beats;

    upd_valid = slot_valid_r;
    if (take) begin
      upd_valid[s] = 1'b1;
    end
    c = upd_valid[1];
    chosen = (take && (c == s)) ? new_slot : slot_r[c];

    res.best_ok      = c;
    res.best_id      = chosen.id;
    res.best_gates   = gates_of(cfg, chosen.converged, chosen.fitness, chosen.ratio,
                                chosen.rmse);
    res.best_fitness = chosen.fitness;
    res.best_ratio   = chosen.ratio;
    res.best_rmse    = chosen.rmse;
    res.best_score   = chosen.score;

    slot_valid_nxt = slot_valid_r;
    if (adv) begin
      slot_valid_nxt = s1_r.last ? 2'b00 : upd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      slot_valid_r <= 2'b00;
      out_valid_r  <= 1'b0;
    end else begin
      slot_valid_r <= slot_valid_nxt;
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv && s1_r.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= in_cand;
    end
    if (adv && take) begin
      slot_r[s] <= new_slot;
    end
    if (adv && s1_r.last) begin
      out_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.best_ok      = out_r.best_ok;
  assign out_ch.best_id      = out_r.best_id;
  assign out_ch.best_gates   = out_r.best_gates;
  assign out_ch.best_fitness = out_r.best_fitness;
  assign out_ch.best_ratio   = out_r.best_ratio;
  assign out_ch.best_rmse    = out_r.best_rmse;
  assign out_ch.best_score   = out_r.best_score;

endmodule

@@ hw/rtl/mcbs_checker.sv @@
module mcbs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  best_gates,
  input logic [15:0] best_id,
  input logic        pready
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(best_id) && $stable(best_gates))
    else $error("result changed while stalled");

  a_gates_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> best_gates <= 3'd4)
    else $error("gate count above four");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready low");

endmodule

bind match_candidate_best_selector mcbs_checker u_mcbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .best_gates (out_ch.best_gates),
  .best_id    (out_ch.best_id),
  .pready     (pready)
);

@@ sim/best_pick_checker.sv @@
module best_pick_checker
  import mcbs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  mcbs_in_if               in_ch,
  mcbs_out_if              out_ch,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic             pready,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output int               errors,
  output int               pending,
  output int               picks_checked
);

  cfg_t    cfg;
  slot_t   store [2];
  bit      held [2];
  result_t expected_picks [$];
  int      mismatches = 0;
  int      checked = 0;

  function automatic logic [GatesW-1:0] gate_count(slot_t k);
    logic [GatesW-1:0] n;
    n = GatesW'(k.converged);
    if (k.fitness <= cfg.fit_limit) n = n + GatesW'(1);
    if (cfg.ratio_floor == '0 || k.ratio >= cfg.ratio_floor) n = n + GatesW'(1);
    if (cfg.rmse_ceil == '0 || k.rmse <= cfg.rmse_ceil) n = n + GatesW'(1);
    return n;
  endfunction

  // strict win only, ties keep the stored candidate
  function automatic bit outranks(slot_t a, slot_t b);
    logic [GatesW-1:0] ga;
    logic [GatesW-1:0] gb;
    ga = gate_count(a);
    gb = gate_count(b);
    if (ga != gb) return ga > gb;
    if (a.ratio != b.ratio) return a.ratio > b.ratio;
    if (a.rmse != b.rmse) return a.rmse < b.rmse;
    if (a.fitness != b.fitness) return a.fitness < b.fitness;
    return a.score < b.score;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    slot_t   fresh;
    result_t want;
    bit      side;
    if (!rst_n) begin
      cfg.fit_limit   = FIT_LIMIT_RST;
      cfg.ratio_floor = '0;
      cfg.rmse_ceil   = '0;
      held[0] = 1'b0;
      held[1] = 1'b0;
      expected_picks.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[AddrW-1:2])
          REG_FIT_LIMIT:   cfg.fit_limit = pwdata[FitW-1:0];
          REG_RATIO_FLOOR: cfg.ratio_floor = pwdata[RatioW-1:0];
          REG_RMSE_CEIL:   cfg.rmse_ceil = pwdata[RmseW-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_picks.size() == 0) begin
          $error("unexpected result, best_id 0x%0h", out_ch.best_id);
          mismatches++;
        end else begin
          want = expected_picks.pop_front();
          check_field("best_ok", 32'(want.best_ok), 32'(out_ch.best_ok));
          check_field("best_id", 32'(want.best_id), 32'(out_ch.best_id));
          check_field("best_gates", 32'(want.best_gates), 32'(out_ch.best_gates));
          check_field("best_fitness", want.best_fitness, out_ch.best_fitness);
          check_field("best_ratio", 32'(want.best_ratio), 32'(out_ch.best_ratio));
          check_field("best_rmse", want.best_rmse, out_ch.best_rmse);
          check_field("best_score", 32'(want.best_score), 32'(out_ch.best_score));
          checked++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        fresh = '{id: in_ch.cand_id, converged: in_ch.converged,
                  fitness: in_ch.fitness, ratio: in_ch.ratio,
                  rmse: in_ch.rmse, score: in_ch.score};
        side = in_ch.success;
        if (!held[side] || outranks(fresh, store[side])) begin
          store[side] = fresh;
          held[side] = 1'b1;
        end
        if (in_ch.last) begin
          // success store wins whenever it holds anything
          side = held[1];
          want.best_ok      = side;
          want.best_id      = store[side].id;
          want.best_gates   = gate_count(store[side]);
          want.best_fitness = store[side].fitness;
          want.best_ratio   = store[side].ratio;
          want.best_rmse    = store[side].rmse;
          want.best_score   = store[side].score;
          expected_picks = {expected_picks, want};
          held[0] = 1'b0;
          held[1] = 1'b0;
        end
      end
    end
    errors        <= mismatches;
    pending       <= expected_picks.size();
    picks_checked <= checked;
  end

endmodule

@@ sim/match_candidate_best_selector_tb.sv @@
module match_candidate_best_selector_tb;
  import mcbs_pkg::*;

  localparam int unsigned QuietLimit = 1000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #4 clk = ~clk;

  mcbs_in_if  in_ch ();
  mcbs_out_if out_ch ();

  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  logic        rsp_ready = 1'b0;
  bit          steady = 1'b0;
  int unsigned hold = 0;
  int unsigned quiet = 0;

  int   errors;
  int   pending;
  int   picks_checked;
  cfg_t cfg_now;
  int   n_items = 0;
  int   n_batches = 0;
  int   n_settings = 1;

  assign out_ch.ready = rsp_ready;

  match_candidate_best_selector dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  best_pick_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .errors        (errors),
    .pending       (pending),
    .picks_checked (picks_checked)
  );

  // result side back-pressure
  always @(posedge clk) begin
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady) begin
      rsp_ready <= 1'b1;
    end else if (hold != 0) begin
      hold <= hold - 1;
      rsp_ready <= 1'b0;
    end else if (r < 70) begin
      rsp_ready <= 1'b1;
    end else if (r < 95) begin
      rsp_ready <= 1'b0;
      hold <= $urandom_range(0, 3);
    end else begin
      rsp_ready <= 1'b0;
      hold <= $urandom_range(10, 50);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
      quiet <= 0;
    end else if (quiet == QuietLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic cand_t mk(bit s, bit conv, logic [FitW-1:0] fit,
                               logic [RatioW-1:0] ratio, logic [RmseW-1:0] rmse,
                               logic [ScoreW-1:0] score, logic [IdW-1:0] id, bit last);
    return '{success: s, converged: conv, fitness: fit, ratio: ratio,
             rmse: rmse, score: score, cand_id: id, last: last};
  endfunction

  function automatic logic [31:0] near32(logic [31:0] thr);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return thr - 32'd1;
      3: return thr;
      4: return thr + 32'd1;
      5: return $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [16:0] near17(logic [16:0] thr);
    case ($urandom_range(0, 8))
      0: return '0;
      1: return 17'h1FFFF;
      2: return thr - 17'd1;
      3: return thr;
      4: return thr + 17'd1;
      5: return 17'($urandom_range(0, 3));
      6: return 17'd65536;
      default: return 17'($urandom);
    endcase
  endfunction

  task automatic send(cand_t c);
    int unsigned r;
    int unsigned gap;
    in_ch.success   <= c.success;
    in_ch.converged <= c.converged;
    in_ch.fitness   <= c.fitness;
    in_ch.ratio     <= c.ratio;
    in_ch.rmse      <= c.rmse;
    in_ch.score     <= c.score;
    in_ch.cand_id   <= c.cand_id;
    in_ch.last      <= c.last;
    in_ch.valid     <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    n_items++;
    if (c.last) n_batches++;
    if (!steady) begin
      r = $urandom_range(0, 99);
      gap = (r < 65) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(6, 40);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop sending and let every pending result drain
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_cfg(logic [FitW-1:0] fit, logic [RatioW-1:0] ratio,
                           logic [RmseW-1:0] rmse);
    settle();
    write_reg(REG_FIT_LIMIT, fit);
    write_reg(REG_RATIO_FLOOR, DataW'(ratio));
    write_reg(REG_RMSE_CEIL, rmse);
    cfg_now = '{fit_limit: fit, ratio_floor: ratio, rmse_ceil: rmse};
    n_settings++;
  endtask

  initial begin
    cand_t       c;
    int unsigned done;
    int unsigned len;
    int unsigned pct;
    in_ch.valid     = 1'b0;
    in_ch.success   = 1'b0;
    in_ch.converged = 1'b0;
    in_ch.fitness   = '0;
    in_ch.ratio     = '0;
    in_ch.rmse      = '0;
    in_ch.score     = '0;
    in_ch.cand_id   = '0;
    in_ch.last      = 1'b0;
    cfg_now = '{fit_limit: FIT_LIMIT_RST, ratio_floor: '0, rmse_ceil: '0};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // failed store: extremes, tie keeps first, ratio tiebreak, last loses
    send(mk(0, 0, '1, 17'h1FFFF, '1, 17'h1FFFF, 16'hFFFF, 0));
    send(mk(0, 1, 0, 0, 0, 0, 16'h0000, 0));
    send(mk(0, 1, 0, 0, 0, 0, 16'h1234, 0));
    send(mk(0, 1, 0, 1, 0, 0, 16'h0005, 0));
    send(mk(0, 1, 100, 1, 0, 0, 16'h0006, 1));
    // success store: fitness gate edge, rmse, score and fitness tiebreaks
    send(mk(1, 1, 32'd65536, 17'd65536, 10, 7, 16'h0100, 0));
    send(mk(1, 1, 32'd65537, 17'd65536, 10, 7, 16'h0101, 0));
    send(mk(1, 1, 32'd65536, 17'd65536, 9, 7, 16'h0102, 0));
    send(mk(1, 1, 32'd65536, 17'd65536, 9, 6, 16'h0103, 0));
    send(mk(1, 1, 32'd65535, 17'd65536, 9, 8, 16'h0104, 0));
    send(mk(0, 1, 0, 17'h1FFFF, 0, 0, 16'h0105, 1));
    send(mk(1, 0, 32'h8000_0000, 17'h0AAAA, 32'h5555_5555, 17'h15555, 16'hA5A5, 1));

    apply_cfg('0, 17'd65536, 32'd1);
    send(mk(0, 0, 0, 17'd65536, 1, 0, 16'h0200, 0));
    send(mk(0, 1, 1, 17'd65535, 2, 0, 16'h0201, 0));
    send(mk(0, 0, 0, 17'h1FFFF, 0, 3, 16'h0202, 0));
    send(mk(0, 1, 0, 17'd65536, 1, 1, 16'h0203, 1));

    apply_cfg('1, 17'd1, '1);
    send(mk(1, 0, '1, 0, '1, 17'h1FFFF, 16'h0300, 0));
    send(mk(1, 1, '1, 1, '1, 17'h1FFFF, 16'h0301, 0));
    send(mk(1, 1, '1, 1, '1, 17'h1FFFF, 16'h0302, 1));

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: apply_cfg(FIT_LIMIT_RST, '0, '0);
        1: apply_cfg('1, 17'd65536, '0);
        2: apply_cfg('0, 17'd1, '1);
        default: apply_cfg(($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 200000),
                           17'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 65536)),
                           ($urandom_range(0, 3) == 0) ? '0 : $urandom);
      endcase
      steady = ($urandom_range(0, 3) == 0);
      done = 0;
      while (done < 84) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
        case ($urandom_range(0, 2))
          0: pct = 0;
          1: pct = 35;
          default: pct = 80;
        endcase
        for (int unsigned i = 0; i < len; i++) begin
          c.success   = ($urandom_range(0, 99) < pct);
          c.converged = 1'($urandom_range(0, 1));
          c.fitness   = near32(cfg_now.fit_limit);
          c.ratio     = near17(cfg_now.ratio_floor);
          c.rmse      = near32(cfg_now.rmse_ceil);
          c.score     = near17('0);
          c.cand_id   = 16'($urandom);
          c.last      = (i == len - 1);
          send(c);
        end
        done += len;
        if ($urandom_range(0, 7) == 0) settle();
      end
    end

    steady = 1'b0;
    settle();
    $display("ran %0d candidates in %0d batches across %0d register settings",
             n_items, n_batches, n_settings);
    $display("%0d selections compared against the predicted best candidate", picks_checked);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ match_candidate_best_selector.f @@
hw/rtl/mcbs_pkg.sv
hw/rtl/mcbs_in_if.sv
hw/rtl/mcbs_out_if.sv
hw/rtl/mcbs_cfg.sv
hw/rtl/match_candidate_best_selector.sv
hw/rtl/mcbs_checker.sv
sim/best_pick_checker.sv
sim/match_candidate_best_selector_tb.sv
